// File: rtl/core/swrf_pkg.sv
package swrf_pkg;

    localparam int MAX_RADIUS = 2;
    localparam int MAX_WIDTH  = 1024;
    localparam int DIM_LIMIT  = 1024;

    localparam int PIX_W      = 32;
    localparam int KEY_W      = 24;
    localparam int ALPHA_W    = 8;
    localparam int COORD_W    = 10;
    localparam int DIM_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK_MODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_RANK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd4;

    // rank selection codes
    localparam logic [1:0] RANK_MEDIAN = 2'd0;
    localparam logic [1:0] RANK_MIN    = 2'd1;
    localparam logic [1:0] RANK_MAX    = 2'd2;
    localparam logic [1:0] RANK_CUSTOM = 2'd3;

    localparam logic [1:0]       RST_RADIUS = 2'd1;
    localparam logic [DIM_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 11'd480;

    typedef logic [PIX_W-1:0] t_pixel;

endpackage

// File: rtl/core/swrf_ram.sv
module swrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/sliding_window_rank_filter_top.sv
// Sliding-window rank filter over a raster pixel stream.
// Input channel (i_valid / o_ready): one pixel per transfer, alpha byte plus
// 24-bit colour key, in raster order. Output channel (o_valid / i_ready): one
// result per window position lying wholly inside the frame, carrying the
// pixel of the selected rank and the window centre coordinates; border
// positions give no result. o_last_pixel marks the result of the frame's
// last pixel.
// Throughput: one pixel per cycle when not stalled. A column memory holds,
// for every column, the last 2*MAX_RADIUS pixels above; each pixel reads its
// column, shifts in and writes back, with forwarding when a one-pixel-wide
// frame reuses the entry at once. The window is a shift register of columns.
// A result passes, after the transfer of the pixel that completes its window,
// through memory read, window shift, pairwise compare, rank count and
// selection into the output register.
// Reset: frame position returns to the top left, registers take their reset
// values, the pipeline empties. The column memory needs no clearing pass.
// Stall: while a result waits unaccepted the whole pipeline holds and o_ready
// drops; the output register parts the two channels.
// Configuration writes of radius, width or height restart the frame; write
// only while idle.
module sliding_window_rank_filter_top #(
    parameter int MAX_RADIUS = swrf_pkg::MAX_RADIUS,
    parameter int MAX_WIDTH  = swrf_pkg::MAX_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [swrf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [swrf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [swrf_pkg::ALPHA_W-1:0]        i_pixel_alpha,
    input  logic [swrf_pkg::KEY_W-1:0]          i_pixel_color,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [swrf_pkg::ALPHA_W-1:0]        o_out_alpha,
    output logic [swrf_pkg::KEY_W-1:0]          o_out_color,
    output logic [swrf_pkg::COORD_W-1:0]        o_out_x,
    output logic [swrf_pkg::COORD_W-1:0]        o_out_y,
    output logic                                o_last_pixel
);

    localparam int SIDE   = 2 * MAX_RADIUS + 1;
    localparam int NCELL  = SIDE * SIDE;
    localparam int HIST_W = swrf_pkg::PIX_W * 2 * MAX_RADIUS;
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CNT_W  = $clog2(NCELL + 1);
    localparam int RW     = (CNT_W > 5) ? CNT_W : 5;
    localparam int WLIM   = (MAX_WIDTH < swrf_pkg::DIM_LIMIT) ? MAX_WIDTH
                                                              : swrf_pkg::DIM_LIMIT;
    localparam int CW     = swrf_pkg::COORD_W;
    localparam int DW     = swrf_pkg::DIM_W;
    localparam int PW     = swrf_pkg::PIX_W;
    localparam int KW     = swrf_pkg::KEY_W;

    // configuration
    logic [1:0]    r_radius;
    logic [1:0]    r_rank_mode;
    logic [4:0]    r_custom_rank;
    logic [DW-1:0] r_width;
    logic [DW-1:0] r_height;

    logic [1:0]    eff_r;
    logic [DW-1:0] eff_w;
    logic [DW-1:0] eff_h;
    logic [CW-1:0] two_r;

    always_comb begin
        eff_r = (32'(r_radius) > MAX_RADIUS) ? 2'(MAX_RADIUS) : r_radius;
        eff_w = (r_width == '0) ? DW'(1) : r_width;
        if (eff_w > DW'(WLIM)) begin
            eff_w = DW'(WLIM);
        end
        eff_h = (r_height == '0) ? DW'(1) : r_height;
        if (eff_h > DW'(swrf_pkg::DIM_LIMIT)) begin
            eff_h = DW'(swrf_pkg::DIM_LIMIT);
        end
        two_r = {{(CW-3){1'b0}}, eff_r, 1'b0};
    end

    // pipeline advance: hold everything while a result waits
    logic en;
    logic r_out_valid;
    logic accept;

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;
    assign accept  = i_valid && en;

    // frame position
    logic [CW-1:0] r_x;
    logic [CW-1:0] r_y;
    logic          geom_wr;

    assign geom_wr = i_cfg_we && (i_cfg_idx == swrf_pkg::CFG_RADIUS ||
                                  i_cfg_idx == swrf_pkg::CFG_IMAGE_WIDTH ||
                                  i_cfg_idx == swrf_pkg::CFG_IMAGE_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius      <= swrf_pkg::RST_RADIUS;
            r_rank_mode   <= swrf_pkg::RANK_MEDIAN;
            r_custom_rank <= '0;
            r_width       <= swrf_pkg::RST_WIDTH;
            r_height      <= swrf_pkg::RST_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                swrf_pkg::CFG_RADIUS:       r_radius      <= i_cfg_data[1:0];
                swrf_pkg::CFG_RANK_MODE:    r_rank_mode   <= i_cfg_data[1:0];
                swrf_pkg::CFG_CUSTOM_RANK:  r_custom_rank <= i_cfg_data[4:0];
                swrf_pkg::CFG_IMAGE_WIDTH:  r_width       <= i_cfg_data;
                swrf_pkg::CFG_IMAGE_HEIGHT: r_height      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || geom_wr) begin
            r_x <= '0;
            r_y <= '0;
        end else if (accept) begin
            if ({1'b0, r_x} + DW'(1) >= eff_w) begin
                r_x <= '0;
                r_y <= ({1'b0, r_y} + DW'(1) >= eff_h) ? '0 : r_y + CW'(1);
            end else begin
                r_x <= r_x + CW'(1);
            end
        end
    end

    // stage 1: column memory read in flight
    logic              r_s1_valid;
    logic [CW-1:0]     r_s1_x;
    logic [CW-1:0]     r_s1_y;
    swrf_pkg::t_pixel  r_s1_word;
    logic              r_s1_hit;
    logic [HIST_W-1:0] r_fwd;
    logic [HIST_W-1:0] ram_q;
    logic [HIST_W-1:0] hist;
    logic [HIST_W-1:0] n_hist;
    logic              s1_fire;

    assign s1_fire = r_s1_valid && en;
    assign hist    = r_s1_hit ? r_fwd : ram_q;
    assign n_hist  = {hist[HIST_W-PW-1:0], r_s1_word};

    swrf_ram #(
        .WIDTH (HIST_W),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (ADDR_W'(r_s1_x)),
        .i_wdata (n_hist),
        .i_re    (accept),
        .i_raddr (ADDR_W'(r_x)),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_hit   <= 1'b0;
        end else if (en) begin
            r_s1_valid <= accept;
            // same column written back this cycle: take it from the bypass
            r_s1_hit   <= accept && r_s1_valid && (r_s1_x == r_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x    <= r_x;
            r_s1_y    <= r_y;
            r_s1_word <= {i_pixel_alpha, i_pixel_color};
        end
        if (s1_fire) begin
            r_fwd <= n_hist;
        end
    end

    // stage 2: window shift register, oldest column on the left
    swrf_pkg::t_pixel r_win [SIDE][SIDE];
    swrf_pkg::t_pixel col   [SIDE];
    logic             r_v2;
    logic [CW-1:0]    r_ox2;
    logic [CW-1:0]    r_oy2;
    logic             r_last2;

    always_comb begin
        col[SIDE-1] = r_s1_word;
        for (int d = 0; d < SIDE - 1; d++) begin
            col[SIDE-2-d] = hist[d*PW +: PW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            for (int ri = 0; ri < SIDE; ri++) begin
                for (int ci = 0; ci < SIDE - 1; ci++) begin
                    r_win[ri][ci] <= r_win[ri][ci+1];
                end
                r_win[ri][SIDE-1] <= col[ri];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= s1_fire && (r_s1_x >= two_r) && (r_s1_y >= two_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ox2   <= r_s1_x - CW'(eff_r);
            r_oy2   <= r_s1_y - CW'(eff_r);
            r_last2 <= ({1'b0, r_s1_x} == eff_w - DW'(1)) &&
                       ({1'b0, r_s1_y} == eff_h - DW'(1));
        end
    end

    // stage 3: pairwise order; cell j ranks below cell i
    logic             act [NCELL];
    swrf_pkg::t_pixel wcell [NCELL];
    logic [NCELL-1:0] below [NCELL];
    logic [NCELL-1:0] r_below3 [NCELL];
    swrf_pkg::t_pixel r_cell3 [NCELL];
    logic [NCELL-1:0] r_act3;
    logic             r_v3;
    logic [CW-1:0]    r_ox3;
    logic [CW-1:0]    r_oy3;
    logic             r_last3;

    always_comb begin
        for (int ri = 0; ri < SIDE; ri++) begin
            for (int ci = 0; ci < SIDE; ci++) begin
                wcell[ri*SIDE+ci] = r_win[ri][ci];
                act[ri*SIDE+ci]   = (ri >= SIDE - 1 - 2 * int'(eff_r)) &&
                                    (ci >= SIDE - 1 - 2 * int'(eff_r));
            end
        end
        for (int i = 0; i < NCELL; i++) begin
            for (int j = 0; j < NCELL; j++) begin
                if (j == i) begin
                    below[i][j] = 1'b0;
                end else if (j < i) begin
                    below[i][j] = act[j] && (wcell[j][KW-1:0] <= wcell[i][KW-1:0]);
                end else begin
                    below[i][j] = act[j] && (wcell[j][KW-1:0] < wcell[i][KW-1:0]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NCELL; i++) begin
                r_below3[i] <= below[i];
                r_cell3[i]  <= wcell[i];
                r_act3[i]   <= act[i];
            end
            r_ox3   <= r_ox2;
            r_oy3   <= r_oy2;
            r_last3 <= r_last2;
        end
    end

    // stage 4: rank of every cell
    logic [CNT_W-1:0] r_pos4 [NCELL];
    swrf_pkg::t_pixel r_cell4 [NCELL];
    logic [NCELL-1:0] r_act4;
    logic             r_v4;
    logic [CW-1:0]    r_ox4;
    logic [CW-1:0]    r_oy4;
    logic             r_last4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NCELL; i++) begin
                r_pos4[i]  <= CNT_W'($countones(r_below3[i]));
                r_cell4[i] <= r_cell3[i];
            end
            r_act4  <= r_act3;
            r_ox4   <= r_ox3;
            r_oy4   <= r_oy3;
            r_last4 <= r_last3;
        end
    end

    // target rank
    logic [RW-1:0] ns_m1;
    logic [RW-1:0] n_side;
    logic [RW-1:0] target;

    always_comb begin
        n_side = RW'({eff_r, 1'b1});
        ns_m1  = RW'(n_side * n_side) - RW'(1);
        case (r_rank_mode)
            swrf_pkg::RANK_MEDIAN: target = {1'b0, ns_m1[RW-1:1]} + RW'(ns_m1[0]);
            swrf_pkg::RANK_MIN:    target = '0;
            swrf_pkg::RANK_MAX:    target = ns_m1;
            swrf_pkg::RANK_CUSTOM: target = (RW'(r_custom_rank) > ns_m1) ? ns_m1
                                                                        : RW'(r_custom_rank);
            default:               target = '0;
        endcase
    end

    // stage 5: select into the output register
    swrf_pkg::t_pixel pick;
    swrf_pkg::t_pixel r_out_pix;
    logic [CW-1:0]    r_out_x;
    logic [CW-1:0]    r_out_y;
    logic             r_out_last;

    always_comb begin
        pick = '0;
        for (int i = 0; i < NCELL; i++) begin
            if (r_act4[i] && (RW'(r_pos4[i]) == target)) begin
                pick = pick | r_cell4[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_pix  <= pick;
            r_out_x    <= r_ox4;
            r_out_y    <= r_oy4;
            r_out_last <= r_last4;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_alpha  = r_out_pix[PW-1:KW];
    assign o_out_color  = r_out_pix[KW-1:0];
    assign o_out_x      = r_out_x;
    assign o_out_y      = r_out_y;
    assign o_last_pixel = r_out_last;

endmodule

// File: rtl/core/swrf_checker.sv
module swrf_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic                         o_ready,
    input logic [swrf_pkg::ALPHA_W-1:0] o_out_alpha,
    input logic [swrf_pkg::KEY_W-1:0]   o_out_color,
    input logic [swrf_pkg::COORD_W-1:0] o_out_x,
    input logic [swrf_pkg::COORD_W-1:0] o_out_y,
    input logic                         o_last_pixel
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_out_color) && $stable(o_out_alpha) &&
            $stable(o_out_x) && $stable(o_out_y) && $stable(o_last_pixel))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("input stalled with a free output register");

endmodule

bind sliding_window_rank_filter_top swrf_checker u_swrf_checker (.*);

// File: tb/sliding_window_rank_filter_top_tb.sv
`timescale 1ns / 1ps

module sliding_window_rank_filter_top_tb;

    localparam int SIDE_MAX   = 2 * swrf_pkg::MAX_RADIUS + 1;
    localparam int CYCLE_CAP  = 200_000;
    localparam int DRAIN_WAIT = 10;

    // one result of the filter
    typedef struct packed {
        logic [swrf_pkg::ALPHA_W-1:0] alpha;
        logic [swrf_pkg::KEY_W-1:0]   color;
        logic [swrf_pkg::COORD_W-1:0] x;
        logic [swrf_pkg::COORD_W-1:0] y;
        logic                         last;
    } t_ranked_pix;

    // one row of the directed table: a pixel, and where obvious its result
    typedef struct {
        logic [swrf_pkg::ALPHA_W-1:0] alpha;
        logic [swrf_pkg::KEY_W-1:0]   color;
        bit                           typed;
        t_ranked_pix                  res;
    } t_dir_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [swrf_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [swrf_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            i_valid;
    logic                            o_ready;
    logic [swrf_pkg::ALPHA_W-1:0]    i_pixel_alpha;
    logic [swrf_pkg::KEY_W-1:0]      i_pixel_color;
    logic                            o_valid;
    logic                            i_ready;
    logic [swrf_pkg::ALPHA_W-1:0]    o_out_alpha;
    logic [swrf_pkg::KEY_W-1:0]      o_out_color;
    logic [swrf_pkg::COORD_W-1:0]    o_out_x;
    logic [swrf_pkg::COORD_W-1:0]    o_out_y;
    logic                            o_last_pixel;

    sliding_window_rank_filter_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel_alpha (i_pixel_alpha),
        .i_pixel_color (i_pixel_color),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_alpha   (o_out_alpha),
        .o_out_color   (o_out_color),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_last_pixel  (o_last_pixel)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------
    // Predictor state: its own copy of line rows, position and registers
    // ---------------------------------------------------------------
    swrf_pkg::t_pixel           row_mem [SIDE_MAX][swrf_pkg::MAX_WIDTH];
    logic [10:0]                col_pos;
    logic [10:0]                row_pos;
    logic [1:0]                 reg_radius;
    logic [1:0]                 reg_mode;
    logic [4:0]                 reg_custom;
    logic [swrf_pkg::DIM_W-1:0] reg_width;
    logic [swrf_pkg::DIM_W-1:0] reg_height;

    t_ranked_pix expected_q[$];
    int          errors;
    int          cycles;

    // typed expectation riding along with the pixel currently on the bus
    bit          cur_typed;
    t_ranked_pix cur_res;

    // apply one register write to the predictor; geometry writes restart the frame
    task automatic model_cfg(input logic [swrf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swrf_pkg::CFG_DATA_W-1:0] d);
        case (idx)
            swrf_pkg::CFG_RADIUS: begin
                reg_radius = d[1:0];
                col_pos = 0;
                row_pos = 0;
            end
            swrf_pkg::CFG_RANK_MODE:   reg_mode = d[1:0];
            swrf_pkg::CFG_CUSTOM_RANK: reg_custom = d[4:0];
            swrf_pkg::CFG_IMAGE_WIDTH: begin
                reg_width = d;
                col_pos = 0;
                row_pos = 0;
            end
            swrf_pkg::CFG_IMAGE_HEIGHT: begin
                reg_height = d;
                col_pos = 0;
                row_pos = 0;
            end
            default: ;
        endcase
    endtask

    // store the pixel, and if its window is whole, rank the window
    task automatic rank_window(input logic [swrf_pkg::ALPHA_W-1:0] a,
                               input logic [swrf_pkg::KEY_W-1:0] c,
                               output bit got, output t_ranked_pix res);
        int               r, n, ns, w, h, x, y, tgt, k, pick, pos, slot;
        swrf_pkg::t_pixel win [SIDE_MAX*SIDE_MAX];
        r  = (reg_radius > swrf_pkg::MAX_RADIUS) ? swrf_pkg::MAX_RADIUS : reg_radius;
        n  = 2 * r + 1;
        ns = n * n;
        w  = (reg_width == 0) ? 1 : reg_width;
        if (w > swrf_pkg::MAX_WIDTH) w = swrf_pkg::MAX_WIDTH;
        if (w > swrf_pkg::DIM_LIMIT) w = swrf_pkg::DIM_LIMIT;
        h  = (reg_height == 0) ? 1 : reg_height;
        if (h > swrf_pkg::DIM_LIMIT) h = swrf_pkg::DIM_LIMIT;
        x  = col_pos % w;
        y  = row_pos % h;
        got = 0;
        res = '0;
        row_mem[y % SIDE_MAX][x] = {a, c};
        if (x >= 2 * r && y >= 2 * r) begin
            k = 0;
            for (int dy = 0; dy < n; dy++) begin
                slot = (y - 2 * r + dy) % SIDE_MAX;
                for (int dx = 0; dx < n; dx++) begin
                    win[k] = row_mem[slot][x - 2 * r + dx];
                    k++;
                end
            end
            case (reg_mode)
                swrf_pkg::RANK_MEDIAN: tgt = ns / 2;
                swrf_pkg::RANK_MIN:    tgt = 0;
                swrf_pkg::RANK_MAX:    tgt = ns - 1;
                default:               tgt = (reg_custom > ns - 1) ? ns - 1 : reg_custom;
            endcase
            pick = 0;
            // ties rank by arrival: the older window cell takes the lower rank
            for (int i = 0; i < ns; i++) begin
                pos = 0;
                for (int j = 0; j < ns; j++)
                    if (win[j][swrf_pkg::KEY_W-1:0] < win[i][swrf_pkg::KEY_W-1:0] ||
                        (win[j][swrf_pkg::KEY_W-1:0] == win[i][swrf_pkg::KEY_W-1:0] &&
                         j < i))
                        pos++;
                if (pos == tgt) begin
                    pick = i;
                    break;
                end
            end
            res.alpha = win[pick][swrf_pkg::PIX_W-1:swrf_pkg::KEY_W];
            res.color = win[pick][swrf_pkg::KEY_W-1:0];
            res.x     = swrf_pkg::COORD_W'(x - r);
            res.y     = swrf_pkg::COORD_W'(y - r);
            res.last  = (x == w - 1 && y == h - 1);
            got = 1;
        end
        if (x + 1 >= w) begin
            col_pos = '0;
            row_pos = (y + 1 >= h) ? 11'd0 : 11'(y + 1);
        end else begin
            col_pos = 11'(x + 1);
            row_pos = 11'(y);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    // ---------------------------------------------------------------
    // Monitor: check the output transfer first, then predict the input one
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_ranked_pix want;
        t_ranked_pix pred;
        bit          got;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result colour", o_out_color, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (o_out_alpha !== want.alpha)
                        report_mismatch("alpha", o_out_alpha, want.alpha);
                    if (o_out_color !== want.color)
                        report_mismatch("colour", o_out_color, want.color);
                    if (o_out_x !== want.x) report_mismatch("x", o_out_x, want.x);
                    if (o_out_y !== want.y) report_mismatch("y", o_out_y, want.y);
                    if (o_last_pixel !== want.last)
                        report_mismatch("last_pixel", o_last_pixel, want.last);
                end
            end
            if (i_valid && o_ready) begin
                rank_window(i_pixel_alpha, i_pixel_color, got, pred);
                // a typed table row stands in place of the prediction
                if (cur_typed) expected_q.push_back(cur_res);
                else if (got) expected_q.push_back(pred);
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: stall pattern drawn at random among four, with stretches of no stalling
    int rx_mode;
    int rx_tick;
    always @(negedge i_clk) begin
        if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
        rx_tick++;
        case (rx_mode)
            0:       i_ready <= 1'b1;
            1:       i_ready <= 1'($urandom_range(0, 1));
            2:       i_ready <= (rx_tick % 3 != 0);
            default: i_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // ---------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------
    int burst_left;

    task automatic send_pixel(input logic [swrf_pkg::ALPHA_W-1:0] a,
                              input logic [swrf_pkg::KEY_W-1:0] c,
                              input bit typed, input t_ranked_pix res);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 40);
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_pixel_alpha <= a;
        i_pixel_color <= c;
        cur_typed     = typed;
        cur_res       = res;
        // hold until the transfer
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
    endtask

    // park the input, drain, then let any result-free pixels leave the pipeline
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        cur_typed = 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [swrf_pkg::CFG_IDX_W-1:0] idx, input int d);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d[swrf_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        model_cfg(idx, d[swrf_pkg::CFG_DATA_W-1:0]);
    endtask

    task automatic set_geometry(input int rad, input int mode, input int cust,
                                input int w, input int h);
        cfg_write(swrf_pkg::CFG_RADIUS, rad);
        cfg_write(swrf_pkg::CFG_RANK_MODE, mode);
        cfg_write(swrf_pkg::CFG_CUSTOM_RANK, cust);
        cfg_write(swrf_pkg::CFG_IMAGE_WIDTH, w);
        cfg_write(swrf_pkg::CFG_IMAGE_HEIGHT, h);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [swrf_pkg::KEY_W-1:0] pick_color(input int flavour);
        case (flavour)
            0:       return 24'($urandom_range(0, 3));       // heavy ties
            1:       return ($urandom_range(0, 1) == 1) ? '1 : '0;
            2:       return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 16'($urandom)};
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_frame(input int count);
        int flavour;
        flavour = $urandom_range(0, 4);
        for (int i = 0; i < count; i++)
            send_pixel(8'($urandom), pick_color(flavour), 0, '0);
    endtask

    t_dir_row    dir_tab[$];
    t_ranked_pix tmp;
    int          sent;
    int          w, h, rad;

    initial begin
        errors     = 0;
        cycles     = 0;
        rx_mode    = 0;
        rx_tick    = 0;
        burst_left = 0;
        cur_typed  = 0;
        cur_res    = '0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_pixel_alpha = '0;
        i_pixel_color = '0;
        i_ready       = 1'b0;
        for (int s = 0; s < SIDE_MAX; s++)
            for (int c = 0; c < swrf_pkg::MAX_WIDTH; c++)
                row_mem[s][c] = '0;
        col_pos    = '0;
        row_pos    = '0;
        reg_radius = swrf_pkg::RST_RADIUS;
        reg_mode   = swrf_pkg::RANK_MEDIAN;
        reg_custom = '0;
        reg_width  = swrf_pkg::RST_WIDTH;
        reg_height = swrf_pkg::RST_HEIGHT;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // after reset: radius and rank keep their reset values, frame narrowed to 5x3
        cfg_write(swrf_pkg::CFG_IMAGE_WIDTH, 5);
        cfg_write(swrf_pkg::CFG_IMAGE_HEIGHT, 3);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        for (int i = 0; i < 15; i++)
            send_pixel(8'($urandom), 24'($urandom), 0, '0);
        wait_idle();

        // radius 0: every pixel is its own result, extremes of both fields
        set_geometry(0, swrf_pkg::RANK_MEDIAN, 0, 4, 2);
        dir_tab = {};
        for (int i = 0; i < 8; i++) begin
            tmp.alpha = (i % 2) ? 8'hFF : 8'h00;
            tmp.color = (i == 1) ? 24'hFFFFFF : (i == 2) ? 24'hAAAAAA
                      : (i == 3) ? 24'h555555 : 24'(i * 24'h010203);
            tmp.x     = swrf_pkg::COORD_W'(i % 4);
            tmp.y     = swrf_pkg::COORD_W'(i / 4);
            tmp.last  = (i == 7);
            dir_tab.push_back('{tmp.alpha, tmp.color, 1, tmp});
        end
        // 3x3 of equal keys, minimum: the oldest pixel wins the tie
        for (int i = 0; i < 9; i++) begin
            tmp = '0;
            dir_tab.push_back('{8'(i + 1), 24'h123456, 0, tmp});
        end
        dir_tab[16].typed = 1;
        dir_tab[16].res   = '{8'd1, 24'h123456, 10'd1, 10'd1, 1'b1};
        // 3x3 of one high key then rising keys, custom rank clamped to the maximum, checked by the predictor
        for (int i = 0; i < 8; i++) begin
            tmp = '0;
            dir_tab.push_back('{8'($urandom), 24'(i * 1000), 0, tmp});
        end
        foreach (dir_tab[i]) begin
            if (i == 8) begin
                wait_idle();
                set_geometry(1, swrf_pkg::RANK_MIN, 0, 3, 3);
            end
            if (i == 17) begin
                wait_idle();
                set_geometry(1, swrf_pkg::RANK_CUSTOM, 31, 3, 3);
                send_pixel(8'h80, 24'hFFFFFE, 0, '0);
            end
            send_pixel(dir_tab[i].alpha, dir_tab[i].color, dir_tab[i].typed, dir_tab[i].res);
        end
        wait_idle();

        // extremes of geometry: widest row wraps into the next one
        set_geometry(0, swrf_pkg::RANK_CUSTOM, 24, 2047, 2047);
        random_frame(1025);
        wait_idle();
        set_geometry(0, swrf_pkg::RANK_MEDIAN, 0, 1, 1024);
        random_frame(40);
        wait_idle();
        set_geometry(3, swrf_pkg::RANK_MAX, 0, 7, 5);
        random_frame(35);
        wait_idle();
        set_geometry(1, swrf_pkg::RANK_MEDIAN, 5, 0, 0);
        random_frame(6);
        wait_idle();

        // random frames, mostly small, partial and repeated
        sent = 0;
        while (sent < 150) begin
            rad = $urandom_range(0, 3);
            w   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) % 24
                                              : $urandom_range(1, 12);
            h   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
            set_geometry(rad, $urandom_range(0, 3), $urandom_range(0, 31), w, h);
            for (int f = $urandom_range(1, 3); f > 0; f--) begin
                random_frame(((w == 0) ? 1 : w) * ((h == 0) ? 1 : h));
                sent += ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
                // change the rank only, the frame runs on
                if ($urandom_range(0, 2) == 0) begin
                    wait_idle();
                    cfg_write(swrf_pkg::CFG_RANK_MODE, $urandom_range(0, 3));
                    cfg_write(swrf_pkg::CFG_CUSTOM_RANK, $urandom_range(0, 31));
                    @(negedge i_clk);
                    i_cfg_we <= 1'b0;
                end
            end
            random_frame($urandom_range(0, 5));
            wait_idle();
        end

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
